[rtl/cdt_pkg.sv]
// Package for the chamfer distance transform unit.
// Holds grid constants, word types, opcodes and sequencer state types.
// No dependencies.
package cdt_pkg;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;
  localparam int CELLS  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int X_W    = $clog2(GRID_W);
  localparam int Y_W    = $clog2(GRID_H);
  localparam int DIST_W = 24;
  localparam int SW_W   = 12;
  localparam int DW_W   = 13;

  localparam logic [DIST_W-1:0] FAR_DIST = {DIST_W{1'b1}};
  localparam logic [SW_W-1:0] STRAIGHT_RESET = SW_W'(1000);
  localparam logic [DW_W-1:0] DIAGONAL_RESET = DW_W'(1414);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic REG_STRAIGHT = 1'b0;
  localparam logic REG_DIAGONAL = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic       occupied;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              unreached;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FWD,
    ST_BWD
  } state_t;

  typedef enum logic [2:0] {
    PH_FETCH,
    PH_NB1,
    PH_NB2,
    PH_NB3,
    PH_NB4
  } phase_t;

endpackage

[rtl/chamfer_distance_transform_unit.sv]
// Top level of the chamfer distance transform unit: distance store,
// pass sequencer and one shared saturating add and compare unit.
// Depends on cdt_pkg.
//
//  channel | direction | handshake            | word
//  cmd     | in        | cmd_valid, cmd_stall | cdt_pkg::cmd_t
//  rsp     | out       | rsp_valid, rsp_stall | cdt_pkg::rsp_t
//  cfg     | in        | wr_en                | wr_index, wr_data
//
// Loads write on accept; reads go via rd0, then wait for a free result register.
// A compute runs a forward and a backward pass, five steps per cell and pass, set by two
// read ports of the store feeding one saturating add and compare unit.
// Reset is synchronous; the store is not cleared and needs no clearing pass.
// A result waits in its register under rsp_stall while the next word is accepted.
module chamfer_distance_transform_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  cdt_pkg::cmd_t              cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output cdt_pkg::rsp_t              rsp,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [cdt_pkg::DW_W-1:0]   wr_data
);

  cdt_pkg::state_t state, state_next;
  cdt_pkg::phase_t phase;

  logic [cdt_pkg::SW_W-1:0]   straight_weight;
  logic [cdt_pkg::DW_W-1:0]   diagonal_weight;
  logic [cdt_pkg::ADDR_W-1:0] addr;
  logic [cdt_pkg::X_W-1:0]    x;
  logic [cdt_pkg::Y_W-1:0]    y;
  logic [cdt_pkg::DIST_W-1:0] m;
  logic                       rd_inside;

  logic [cdt_pkg::DIST_W-1:0] store [cdt_pkg::CELLS];
  logic [cdt_pkg::DIST_W-1:0] rd0, rd1;
  logic                       rd0_en, rd1_en, store_we;
  logic [cdt_pkg::ADDR_W-1:0] ra0, ra1, wa;
  logic [cdt_pkg::DIST_W-1:0] wd;

  logic                       accept, in_grid, fwd, last_cell, rsp_free;
  logic [cdt_pkg::ADDR_W-1:0] cmd_addr, n1, n2, n3, n4;
  logic                       e1, e2, e3, e4, lo_x, hi_x, lo_y, hi_y;

  logic [cdt_pkg::DIST_W-1:0] ucur, uopnd, usat, uout;
  logic [cdt_pkg::DIST_W:0]   usum, uw;
  logic                       uok;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != cdt_pkg::ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign in_grid   = (32'(cmd.cell_x) < 32'(cdt_pkg::GRID_W)) &&
                     (32'(cmd.cell_y) < 32'(cdt_pkg::GRID_H));
  assign cmd_addr  = cdt_pkg::ADDR_W'(cmd.cell_y) * cdt_pkg::ADDR_W'(cdt_pkg::GRID_W) +
                     cdt_pkg::ADDR_W'(cmd.cell_x);

  assign fwd  = (state == cdt_pkg::ST_FWD);
  assign lo_x = (x == '0);
  assign hi_x = (x == cdt_pkg::X_W'(cdt_pkg::GRID_W - 1));
  assign lo_y = (y == '0);
  assign hi_y = (y == cdt_pkg::Y_W'(cdt_pkg::GRID_H - 1));
  assign last_cell = fwd ? (addr == cdt_pkg::ADDR_W'(cdt_pkg::CELLS - 1)) : (addr == '0);

  always_comb begin
    if (fwd) begin
      n1 = addr - cdt_pkg::ADDR_W'(1);
      n2 = addr - cdt_pkg::ADDR_W'(cdt_pkg::GRID_W);
      n3 = addr - cdt_pkg::ADDR_W'(cdt_pkg::GRID_W + 1);
      n4 = addr - cdt_pkg::ADDR_W'(cdt_pkg::GRID_W - 1);
      e1 = !lo_x;
      e2 = !lo_y;
      e3 = !lo_y && !lo_x;
      e4 = !lo_y && !hi_x;
    end else begin
      n1 = addr + cdt_pkg::ADDR_W'(1);
      n2 = addr + cdt_pkg::ADDR_W'(cdt_pkg::GRID_W);
      n3 = addr + cdt_pkg::ADDR_W'(cdt_pkg::GRID_W + 1);
      n4 = addr + cdt_pkg::ADDR_W'(cdt_pkg::GRID_W - 1);
      e1 = !hi_x;
      e2 = !hi_y;
      e3 = !hi_y && !hi_x;
      e4 = !hi_y && !lo_x;
    end
  end

  // Shared unit: saturating add of a neighbor and its weight, then keep the smaller.
  always_comb begin
    ucur  = m;
    uopnd = rd0;
    uw    = (cdt_pkg::DIST_W + 1)'(straight_weight);
    uok   = 1'b0;
    case (phase)
      cdt_pkg::PH_NB1: begin
        ucur  = rd0;
        uopnd = rd1;
        uok   = e1;
      end
      cdt_pkg::PH_NB2: begin
        uopnd = rd0;
        uok   = e2;
      end
      cdt_pkg::PH_NB3: begin
        uopnd = rd1;
        uw    = (cdt_pkg::DIST_W + 1)'(diagonal_weight);
        uok   = e3;
      end
      cdt_pkg::PH_NB4: begin
        uopnd = rd0;
        uw    = (cdt_pkg::DIST_W + 1)'(diagonal_weight);
        uok   = e4;
      end
      default: begin
        uok = 1'b0;
      end
    endcase
    usum = {1'b0, uopnd} + uw;
    usat = usum[cdt_pkg::DIST_W] ? cdt_pkg::FAR_DIST : usum[cdt_pkg::DIST_W-1:0];
    uout = (uok && (usat < ucur)) ? usat : ucur;
  end

  always_comb begin
    state_next = state;
    rd0_en     = 1'b0;
    rd1_en     = 1'b0;
    ra0        = addr;
    ra1        = n1;
    store_we   = 1'b0;
    wa         = addr;
    wd         = uout;
    case (state)
      cdt_pkg::ST_IDLE: begin
        ra0 = cmd_addr;
        wa  = cmd_addr;
        wd  = cmd.occupied ? '0 : cdt_pkg::FAR_DIST;
        if (accept) begin
          case (cmd.opcode)
            cdt_pkg::OP_LOAD: begin
              store_we = in_grid;
            end
            cdt_pkg::OP_COMPUTE: begin
              state_next = cdt_pkg::ST_FWD;
            end
            cdt_pkg::OP_READ: begin
              rd0_en     = 1'b1;
              state_next = cdt_pkg::ST_READ;
            end
            default: begin
              state_next = cdt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      cdt_pkg::ST_READ: begin
        if (rsp_free) begin
          state_next = cdt_pkg::ST_IDLE;
        end
      end
      cdt_pkg::ST_FWD, cdt_pkg::ST_BWD: begin
        case (phase)
          cdt_pkg::PH_FETCH: begin
            rd0_en = 1'b1;
            rd1_en = 1'b1;
          end
          cdt_pkg::PH_NB1: begin
            rd0_en = 1'b1;
            rd1_en = 1'b1;
            ra0    = n2;
            ra1    = n3;
          end
          cdt_pkg::PH_NB2: begin
            rd0_en = 1'b1;
            ra0    = n4;
          end
          cdt_pkg::PH_NB4: begin
            store_we = 1'b1;
            if (last_cell) begin
              state_next = fwd ? cdt_pkg::ST_BWD : cdt_pkg::ST_IDLE;
            end
          end
          default: begin
            rd0_en = 1'b0;
          end
        endcase
      end
      default: begin
        state_next = cdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wa] <= wd;
    end
    if (rd0_en) begin
      rd0 <= store[ra0];
    end
    if (rd1_en) begin
      rd1 <= store[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      straight_weight <= cdt_pkg::STRAIGHT_RESET;
      diagonal_weight <= cdt_pkg::DIAGONAL_RESET;
    end else if (wr_en) begin
      if (wr_index == cdt_pkg::REG_STRAIGHT) begin
        straight_weight <= wr_data[cdt_pkg::SW_W-1:0];
      end else if (wr_index == cdt_pkg::REG_DIAGONAL) begin
        diagonal_weight <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cdt_pkg::PH_FETCH;
      addr  <= '0;
      x     <= '0;
      y     <= '0;
    end else if (state == cdt_pkg::ST_IDLE) begin
      phase <= cdt_pkg::PH_FETCH;
      addr  <= '0;
      x     <= '0;
      y     <= '0;
    end else if (state == cdt_pkg::ST_FWD || state == cdt_pkg::ST_BWD) begin
      case (phase)
        cdt_pkg::PH_FETCH: phase <= cdt_pkg::PH_NB1;
        cdt_pkg::PH_NB1:   phase <= cdt_pkg::PH_NB2;
        cdt_pkg::PH_NB2:   phase <= cdt_pkg::PH_NB3;
        cdt_pkg::PH_NB3:   phase <= cdt_pkg::PH_NB4;
        default: begin
          phase <= cdt_pkg::PH_FETCH;
          if (!last_cell) begin
            if (fwd) begin
              addr <= addr + cdt_pkg::ADDR_W'(1);
              if (hi_x) begin
                x <= '0;
                y <= y + cdt_pkg::Y_W'(1);
              end else begin
                x <= x + cdt_pkg::X_W'(1);
              end
            end else begin
              addr <= addr - cdt_pkg::ADDR_W'(1);
              if (lo_x) begin
                x <= cdt_pkg::X_W'(cdt_pkg::GRID_W - 1);
                y <= y - cdt_pkg::Y_W'(1);
              end else begin
                x <= x - cdt_pkg::X_W'(1);
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase != cdt_pkg::PH_FETCH) begin
      m <= uout;
    end
    if (accept) begin
      rd_inside <= in_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == cdt_pkg::ST_READ && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cdt_pkg::ST_READ && rsp_free) begin
      rsp.distance  <= rd_inside ? rd0 : cdt_pkg::FAR_DIST;
      rsp.unreached <= !rd_inside || (rd0 == cdt_pkg::FAR_DIST);
    end
  end

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == cdt_pkg::OP_COMPUTE |=> state == cdt_pkg::ST_FWD)
    else $error("compute word did not start the forward pass");

  a_pass_write_phase: assert property (@(posedge clk) disable iff (rst)
    (state == cdt_pkg::ST_FWD || state == cdt_pkg::ST_BWD) && store_we
      |-> phase == cdt_pkg::PH_NB4)
    else $error("store written outside the final step of a cell");

  a_read_delivers: assert property (@(posedge clk) disable iff (rst)
    state == cdt_pkg::ST_READ && rsp_free |=> rsp_valid && state == cdt_pkg::ST_IDLE)
    else $error("read result not placed in the result register");

  a_idle_cursor: assert property (@(posedge clk) disable iff (rst)
    state == cdt_pkg::ST_IDLE |-> addr == '0 && phase == cdt_pkg::PH_FETCH)
    else $error("pass cursor not at rest while idle");

endmodule
